FILE: src/cst_pkg.sv
// Shared types and constants for the counting semaphore table.
package cst_pkg;

  localparam int CNT_W = 16;
  localparam int REQ_ID_W = 16;

  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [CNT_W-1:0] CNT_ONE = 16'sh0001;

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_WAIT    = 2'd2,
    KIND_SIGNAL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } sts_t;

endpackage

FILE: src/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/cst_ctrl.sv
// Controller: request sequencing between lookup and update.
module cst_ctrl import cst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_valid || m_tready) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/cst_dp.sv
// Datapath: slot id lanes, count memory, id counter and output register.
module cst_dp import cst_pkg::*; #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          in_kind,
  input  logic [REQ_ID_W-1:0] in_target_id,
  input  logic [CNT_W-1:0]    in_initial_count,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [1:0]          out_status,
  output logic [REQ_ID_W-1:0] out_assigned_id,
  output logic                out_block_caller,
  output logic                out_wake_one
);

  localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CMP_W = ID_BITS > REQ_ID_W ? ID_BITS : REQ_ID_W;

  logic [SLOTS-1:0]   used;
  logic [ID_BITS-1:0] ids [SLOTS];
  logic [ID_BITS-1:0] next_id;

  logic [SLOTS-1:0] hit;
  logic [IDX_W-1:0] hit_idx;
  logic             hit_any;
  logic [IDX_W-1:0] free_idx;
  logic             free_any;
  logic [IDX_W-1:0] look_idx;

  kind_t             req_kind;
  logic [CNT_W-1:0]  req_init;
  logic [IDX_W-1:0]  idx;
  logic              found;

  logic [CNT_W-1:0]        rdata;
  logic signed [CNT_W-1:0] cnt;
  logic signed [CNT_W-1:0] cnt_dec;
  logic signed [CNT_W-1:0] cnt_inc;
  logic                    ram_we;
  logic [CNT_W-1:0]        ram_wdata;

  status_t             status_next;
  logic [REQ_ID_W-1:0] assigned_next;
  logic                block_next;
  logic                wake_next;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = used[i] && (CMP_W'(ids[i]) == CMP_W'(in_target_id));
    end
  end

  always_comb begin
    hit_idx  = '0;
    hit_any  = 1'b0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IDX_W'(i);
        hit_any = 1'b1;
      end
      if (!used[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign look_idx = (kind_t'(in_kind) == KIND_CREATE) ? free_idx : hit_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= kind_t'(in_kind);
      req_init <= in_initial_count;
      idx      <= look_idx;
      found    <= (kind_t'(in_kind) == KIND_CREATE) ? free_any : hit_any;
    end
  end

  cst_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SLOTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (look_idx),
    .rdata (rdata)
  );

  assign cnt     = signed'(rdata);
  assign cnt_dec = (cnt == CNT_MIN) ? cnt : cnt - CNT_ONE;
  assign cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + CNT_ONE;

  always_comb begin
    ram_we        = 1'b0;
    ram_wdata     = req_init;
    status_next   = ST_OK;
    assigned_next = '0;
    block_next    = 1'b0;
    wake_next     = 1'b0;
    if (!found) begin
      status_next = (req_kind == KIND_CREATE) ? ST_FULL : ST_NOT_FOUND;
    end else begin
      unique case (req_kind)
        KIND_CREATE: begin
          ram_we        = cmd.exec;
          ram_wdata     = req_init;
          assigned_next = REQ_ID_W'(CMP_W'(next_id));
        end
        KIND_DESTROY: ;
        KIND_WAIT: begin
          ram_we     = cmd.exec;
          ram_wdata  = cnt_dec;
          block_next = cnt_dec < 0;
        end
        KIND_SIGNAL: begin
          ram_we    = cmd.exec;
          ram_wdata = cnt_inc;
          wake_next = cnt_inc <= 0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      next_id <= '0;
    end else if (cmd.exec && found) begin
      if (req_kind == KIND_CREATE) begin
        used[idx] <= 1'b1;
        next_id   <= next_id + ID_BITS'(1);
      end else if (req_kind == KIND_DESTROY) begin
        used[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && found && req_kind == KIND_CREATE) begin
      ids[idx] <= next_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status       <= status_next;
      out_assigned_id  <= assigned_next;
      out_block_caller <= block_next;
      out_wake_one     <= wake_next;
    end
  end

  assign sts.out_valid = m_tvalid;

endmodule

FILE: src/counting_semaphore_table_unit.sv
// Top level of the counting semaphore table.
//
// A request is handled in a lookup step and an update step: in the cycle of its transfer
// the ids of all SLOTS entries are compared at once and the lowest matching (or lowest
// free) slot is picked and its count read from the count RAM; in the update step (state
// S_EXEC) the count, slot state and id counter are updated and the result is loaded into
// the output register. A new request is taken once the update is done; the update waits
// while the output register still holds a result that has not been transferred.
// No clearing pass is needed after reset.
module counting_semaphore_table_unit import cst_pkg::*; #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // target_id[15:0], initial_count[31:16]
  input  logic [1:0]  s_tuser,  // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // assigned_id[15:0], block_caller[16], wake_one[17], zero
  output logic [1:0]  m_tuser   // status[1:0]
);

  cmd_t cmd;
  sts_t sts;

  logic [REQ_ID_W-1:0] assigned_id;
  logic                block_caller;
  logic                wake_one;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cst_dp #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (s_tuser),
    .in_target_id     (s_tdata[15:0]),
    .in_initial_count (s_tdata[31:16]),
    .m_tready         (m_tready),
    .m_tvalid         (m_tvalid),
    .out_status       (m_tuser),
    .out_assigned_id  (assigned_id),
    .out_block_caller (block_caller),
    .out_wake_one     (wake_one)
  );

  assign m_tdata = {6'd0, wake_one, block_caller, assigned_id};

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.exec))
    else $error("result appeared without an update step");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOT_FOUND || m_tuser == ST_FULL))
    else $error("undefined status code");

  a_id_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[15:0] == 16'd0 && !m_tdata[16] && !m_tdata[17])
    else $error("payload set on a failed request");

endmodule

FILE: bench/semaphore_table_checker.sv
// Checker for the semaphore table: predicts each reply from the request stream and compares.
module semaphore_table_checker import cst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    logic [15:0] assigned_id;
    logic        block_caller;
    logic        wake_one;
  } sema_reply_t;

  logic                    slot_busy [SLOTS];
  logic [REQ_ID_W-1:0]     slot_tag  [SLOTS];
  logic signed [CNT_W-1:0] slot_cnt  [SLOTS];
  logic [REQ_ID_W-1:0]     id_counter;
  sema_reply_t             replies_due [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
    end
  endtask

  function automatic sema_reply_t apply_request(kind_t op, logic [REQ_ID_W-1:0] tid,
                                                logic signed [CNT_W-1:0] init);
    sema_reply_t r;
    int hit;
    r = '{status: ST_OK, assigned_id: '0, block_caller: 1'b0, wake_one: 1'b0};
    hit = -1;
    if (op == KIND_CREATE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_busy[i] && hit < 0) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_FULL;
      end else begin
        slot_busy[hit] = 1'b1;
        slot_tag[hit] = id_counter;
        slot_cnt[hit] = init;
        r.assigned_id = id_counter;
        id_counter = id_counter + 1'b1;
      end
    end else begin
      // lowest matching slot wins when ids repeat after wrap
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[i] && slot_tag[i] == tid && hit < 0) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        case (op)
          KIND_DESTROY: begin
            slot_busy[hit] = 1'b0;
          end
          KIND_WAIT: begin
            if (slot_cnt[hit] != CNT_MIN) slot_cnt[hit] = slot_cnt[hit] - CNT_ONE;
            r.block_caller = slot_cnt[hit][CNT_W-1];
          end
          KIND_SIGNAL: begin
            if (slot_cnt[hit] != CNT_MAX) slot_cnt[hit] = slot_cnt[hit] + CNT_ONE;
            r.wake_one = slot_cnt[hit][CNT_W-1] || slot_cnt[hit] == '0;
          end
          default: begin
          end
        endcase
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sema_reply_t got;
    sema_reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
      id_counter = '0;
      replies_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tuser);
        got.assigned_id = m_tdata[15:0];
        got.block_caller = m_tdata[16];
        got.wake_one = m_tdata[17];
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected transfer", 32'(got), '0);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.assigned_id !== want.assigned_id)
            report_mismatch("assigned_id", 32'(got.assigned_id), 32'(want.assigned_id));
          if (got.block_caller !== want.block_caller)
            report_mismatch("block_caller", 32'(got.block_caller), 32'(want.block_caller));
          if (got.wake_one !== want.wake_one)
            report_mismatch("wake_one", 32'(got.wake_one), 32'(want.wake_one));
        end
      end
      if (s_tvalid && s_tready) begin
        replies_due.push_back(apply_request(kind_t'(s_tuser), s_tdata[15:0], s_tdata[31:16]));
      end
    end
    pending = replies_due.size();
  end

endmodule

FILE: bench/counting_semaphore_table_unit_tb.sv
// Testbench top for the semaphore table: request stimulus, reply back-pressure and verdict.
module counting_semaphore_table_unit_tb import cst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  int          errors;
  int          pending;

  logic        no_gaps = 1'b0;
  logic        rx_fire = 1'b0;
  int          rx_hold = 0;

  logic [15:0] live_ids [$];
  logic [15:0] next_tag = '0;

  counting_semaphore_table_unit #(
    .SLOTS  (SLOT_COUNT),
    .ID_BITS(16)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  semaphore_table_checker #(
    .SLOTS(SLOT_COUNT)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // reply side stall after each transfer
  always @(posedge clk) rx_fire <= m_tvalid && m_tready;

  always @(negedge clk) begin
    if (rx_fire) rx_hold = no_gaps ? 0 : $urandom_range(0, 7);
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic drive_request(kind_t op, logic [15:0] tid, logic [15:0] init);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {init, tid};
    do @(posedge clk); while (!s_tready);
  endtask

  // drive one request and track which ids should be live
  task automatic issue(kind_t op, logic [15:0] tid, logic [15:0] init);
    int hit;
    hit = -1;
    drive_request(op, tid, init);
    if (op == KIND_CREATE) begin
      if (live_ids.size() < SLOT_COUNT) begin
        live_ids.push_back(next_tag);
        next_tag++;
      end
    end else if (op == KIND_DESTROY) begin
      for (int i = 0; i < live_ids.size(); i++) begin
        if (live_ids[i] == tid && hit < 0) hit = i;
      end
      if (hit >= 0) live_ids.delete(hit);
    end
  endtask

  initial begin
    kind_t       op;
    logic [15:0] tid;
    logic [15:0] init;
    int          pick;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // counts at the extremes, zero crossings, unknown ids, ignored fields
    issue(KIND_CREATE, 16'hffff, CNT_MAX);
    issue(KIND_CREATE, 16'h0000, CNT_MIN);
    issue(KIND_CREATE, 16'h1234, 16'h0000);
    issue(KIND_CREATE, 16'h8000, 16'hffff);
    issue(KIND_WAIT, 16'd1, CNT_MAX);
    issue(KIND_SIGNAL, 16'd0, CNT_MIN);
    issue(KIND_WAIT, 16'd2, 16'h5555);
    issue(KIND_SIGNAL, 16'd2, 16'h0000);
    issue(KIND_SIGNAL, 16'd2, 16'haaaa);
    issue(KIND_WAIT, 16'd3, 16'h0000);
    issue(KIND_DESTROY, 16'hffff, 16'h0000);
    issue(KIND_WAIT, 16'h8000, 16'h0000);
    issue(KIND_SIGNAL, 16'd4, 16'h0000);
    // fill the table, then overflow it
    repeat (12) issue(KIND_CREATE, 16'($urandom()), 16'($urandom()));
    issue(KIND_CREATE, 16'h0000, 16'h0001);
    issue(KIND_DESTROY, 16'd5, 16'h7777);
    issue(KIND_CREATE, 16'h0000, 16'h0002);
    issue(KIND_DESTROY, 16'd2, 16'h0000);

    while (live_ids.size() > 13) issue(KIND_DESTROY, live_ids[$], 16'h0000);
    issue(KIND_CREATE, 16'h0000, 16'hfffe);
    issue(KIND_CREATE, 16'h0000, 16'h0003);
    issue(KIND_SIGNAL, 16'd0, 16'h0000);
    issue(KIND_WAIT, 16'd1, 16'h0000);
    issue(KIND_DESTROY, 16'd0, 16'h0000);
    issue(KIND_WAIT, 16'd0, 16'h0000);

    for (int n = 0; n < 750; n++) begin
      if (n % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 12);
      if (pick < 3) op = KIND_CREATE;
      else if (pick < 5) op = KIND_DESTROY;
      else if (pick < 9) op = KIND_WAIT;
      else op = KIND_SIGNAL;
      if (live_ids.size() > 0 && $urandom_range(0, 9) < 8)
        tid = live_ids[$urandom_range(0, live_ids.size() - 1)];
      else
        tid = 16'($urandom());
      case ($urandom_range(0, 3))
        0: init = 16'($urandom());
        1: init = $urandom_range(0, 1) ? CNT_MAX : CNT_MIN;
        default: init = 16'($urandom_range(0, 6) - 3);
      endcase
      issue(op, tid, init);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
